### rtl/nvsde_pkg.sv
// Package for the Ninomiya-Victoir SDE step unit: sequencer states, step codes,
// register indexes, the sine polynomial and phase constants, and reset values.
// No dependencies.
package nvsde_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_POST = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        OP_R1A, OP_R1B, OP_R2A, OP_R2B,
        OP_PH, OP_SQ, OP_H9, OP_H7, OP_H5, OP_H3, OP_H1, OP_SU, OP_KK
    } op_t;

    localparam logic [1:0] REG_COS    = 2'd0;
    localparam logic [1:0] REG_SIN    = 2'd1;
    localparam logic [1:0] REG_START1 = 2'd2;
    localparam logic [1:0] REG_START2 = 2'd3;

    localparam logic signed [63:0] TURN_K = 64'sh28BE60DB9391054A;
    localparam logic signed [63:0] C1  = 64'sd1686629713;
    localparam logic signed [63:0] C3  = -64'sd693598669;
    localparam logic signed [63:0] C5  = 64'sd85569306;
    localparam logic signed [63:0] C7  = -64'sd5026994;
    localparam logic signed [63:0] C9  = 64'sd172271;
    localparam logic signed [63:0] C11 = -64'sd3864;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
    localparam logic signed [63:0] TWO_Q30 = 64'sd2147483648;
    localparam logic signed [31:0] RST_COS   = 32'sd1073741824;
    localparam logic signed [31:0] RST_SIN   = 32'sd0;
    localparam logic signed [31:0] RST_START = 32'sd16777216;

endpackage

### rtl/ninomiya_victoir_sde_step_unit.sv
// Top level of the Ninomiya-Victoir SDE step unit: one shared 32x32 multiplier
// with a 128-bit accumulator, run by a small sequencer. Depends on nvsde_pkg.
//
// Each accepted input beat runs a load state, 26 multiplies (each summing four
// 32x32 partial products, then applying the sign, then a post step) and an output
// state before m_tvalid. A new item is taken only after the last is issued; s_tready is
// high only when idle, and a result not yet taken holds the unit in its output state.
// Reset (aresetn, synchronous): control and configuration registers to their reset
// values (datapath registers are not reset), state to the start point, no result pending.
module ninomiya_victoir_sde_step_unit #(
    parameter int STATE_WIDTH = 32,
    parameter int FRAC_BITS   = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // noise_one, noise_two
    input  logic [1:0]  s_tuser,   // order_bit, new_path
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pos_one, pos_two
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import nvsde_pkg::*;

    localparam logic signed [127:0] ST_MAX = (128'sd1 <<< (STATE_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] ST_MIN = -(128'sd1 <<< (STATE_WIDTH - 1));
    localparam logic signed [127:0] O_MAX  = 128'sd2147483647;
    localparam logic signed [127:0] O_MIN  = -128'sd2147483648;

    function automatic logic signed [STATE_WIDTH-1:0] sat_st(logic signed [127:0] v);
        logic signed [127:0] r;
        r = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
        return r[STATE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] sat_out(logic signed [STATE_WIDTH-1:0] x);
        logic signed [127:0] v;
        logic signed [127:0] r;
        v = 128'(x);
        r = (v > O_MAX) ? O_MAX : ((v < O_MIN) ? O_MIN : v);
        return r[31:0];
    endfunction

    function automatic logic signed [127:0] rnd30(logic signed [127:0] v);
        return (v + 128'sd536870912) >>> 30;
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [2:0] cnt_reg, cnt_next;
    logic signed [31:0] cos_reg, sin_reg, st1_reg, st2_reg;
    logic signed [STATE_WIDTH-1:0] x1_reg, x1_next, x2_reg, x2_next, t1_reg, t1_next;
    logic signed [31:0] n1_reg, n1_next, n2_reg, n2_next;
    logic order_reg, order_next, rot2_reg, rot2_next, kick_reg, kick_next;
    logic [63:0] mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic neg_reg, neg_next;
    logic signed [127:0] acc_reg, acc_next, sum_reg, sum_next;
    logic signed [63:0] v_reg, v_next;
    logic [30:0] u_reg, u_next;
    logic [1:0] quad_reg, quad_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic go;
    logic signed [63:0] go_a, go_b;
    op_t go_op;

    logic [31:0] pa, pb;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    logic tgt_one;
    logic signed [127:0] rp;
    logic signed [63:0] r_s, vol;
    logic [31:0] ph;
    logic signed [STATE_WIDTH-1:0] kicked;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        pa = cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
        pb = cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        pp = pa * pb;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        x1_next = x1_reg;
        x2_next = x2_reg;
        t1_next = t1_reg;
        n1_next = n1_reg;
        n2_next = n2_reg;
        order_next = order_reg;
        rot2_next = rot2_reg;
        kick_next = kick_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        sum_next = sum_reg;
        v_next = v_reg;
        u_next = u_reg;
        quad_next = quad_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        go = 1'b0;
        go_a = '0;
        go_b = '0;
        go_op = OP_R1A;
        tgt_one = kick_reg ? !order_reg : order_reg;
        rp = rnd30(acc_reg);
        ph = acc_reg[FRAC_BITS+32 +: 32];
        r_s = rp[63:0];
        if (r_s < 64'sd0) r_s = 64'sd0;
        if (r_s > ONE_Q30) r_s = ONE_Q30;
        vol = TWO_Q30 + (quad_reg[1] ? -r_s : r_s);
        kicked = sat_st(128'(tgt_one ? x1_reg : x2_reg) + rp);

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n1_next = s_tdata[31:0];
                    n2_next = s_tdata[63:32];
                    order_next = s_tuser[0];
                    if (s_tuser[1]) begin
                        x1_next = sat_st(128'(st1_reg));
                        x2_next = sat_st(128'(st2_reg));
                    end
                    rot2_next = 1'b0;
                    kick_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                go = 1'b1; go_a = 64'(cos_reg); go_b = 64'(x1_reg); go_op = OP_R1A;
            end
            ST_MUL: begin
                if (cnt_reg == 3'd4) begin
                    acc_next = neg_reg ? -acc_reg : acc_reg;
                    state_next = ST_POST;
                end else begin
                    acc_next = acc_reg + $signed(pp_sh);
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_POST: begin
                case (op_reg)
                    OP_R1A: begin
                        sum_next = acc_reg;
                        go = 1'b1; go_a = 64'(sin_reg); go_b = 64'(x2_reg); go_op = OP_R1B;
                    end
                    OP_R1B: begin
                        t1_next = sat_st(rnd30(sum_reg + acc_reg));
                        go = 1'b1; go_a = 64'(cos_reg); go_b = 64'(x2_reg); go_op = OP_R2A;
                    end
                    OP_R2A: begin
                        sum_next = acc_reg;
                        go = 1'b1; go_a = -64'(sin_reg); go_b = 64'(x1_reg); go_op = OP_R2B;
                    end
                    OP_R2B: begin
                        x1_next = t1_reg;
                        x2_next = sat_st(rnd30(sum_reg + acc_reg));
                        if (rot2_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            go = 1'b1; go_b = TURN_K; go_op = OP_PH;
                            go_a = order_reg ? 64'(sat_st(rnd30(sum_reg + acc_reg)))
                                             : 64'(t1_reg);
                        end
                    end
                    OP_PH: begin
                        quad_next = ph[31:30];
                        u_next = ph[30] ? (31'h40000000 - {1'b0, ph[29:0]})
                                        : {1'b0, ph[29:0]};
                        go = 1'b1; go_op = OP_SQ;
                        go_a = ph[30] ? 64'(31'h40000000 - {1'b0, ph[29:0]})
                                      : 64'({1'b0, ph[29:0]});
                        go_b = go_a;
                    end
                    OP_SQ: begin
                        v_next = rp[63:0];
                        go = 1'b1; go_a = C11; go_b = rp[63:0]; go_op = OP_H9;
                    end
                    OP_H9, OP_H7, OP_H5, OP_H3: begin
                        go = 1'b1; go_b = v_reg;
                        case (op_reg)
                            OP_H9:   begin go_a = C9 + rp[63:0]; go_op = OP_H7; end
                            OP_H7:   begin go_a = C7 + rp[63:0]; go_op = OP_H5; end
                            OP_H5:   begin go_a = C5 + rp[63:0]; go_op = OP_H3; end
                            default: begin go_a = C3 + rp[63:0]; go_op = OP_H1; end
                        endcase
                    end
                    OP_H1: begin
                        go = 1'b1; go_a = C1 + rp[63:0]; go_b = 64'(u_reg); go_op = OP_SU;
                    end
                    OP_SU: begin
                        go = 1'b1; go_a = 64'(tgt_one ? n1_reg : n2_reg); go_b = vol;
                        go_op = OP_KK;
                    end
                    OP_KK: begin
                        if (tgt_one) x1_next = kicked;
                        else x2_next = kicked;
                        go = 1'b1;
                        if (!kick_reg) begin
                            kick_next = 1'b1;
                            go_a = 64'(kicked); go_b = TURN_K; go_op = OP_PH;
                        end else begin
                            rot2_next = 1'b1;
                            go_a = 64'(cos_reg); go_op = OP_R1A;
                            go_b = tgt_one ? 64'(kicked) : 64'(x1_reg);
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {sat_out(x2_reg), sat_out(x1_reg)};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (go) begin
            mag_a_next = go_a[63] ? 64'(-go_a) : 64'(go_a);
            mag_b_next = go_b[63] ? 64'(-go_b) : 64'(go_b);
            neg_next = go_a[63] ^ go_b[63];
            acc_next = '0;
            cnt_next = '0;
            op_next = go_op;
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cos_reg <= RST_COS;
            sin_reg <= RST_SIN;
            st1_reg <= RST_START;
            st2_reg <= RST_START;
            x1_reg <= sat_st(128'(RST_START));
            x2_reg <= sat_st(128'(RST_START));
            m_tvalid_reg <= 1'b0;
            op_reg <= OP_R1A;
            cnt_reg <= '0;
            rot2_reg <= 1'b0;
            kick_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            x1_reg <= x1_next;
            x2_reg <= x2_next;
            m_tvalid_reg <= m_tvalid_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
            rot2_reg <= rot2_next;
            kick_reg <= kick_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_COS:    cos_reg <= cfg_wdata;
                    REG_SIN:    sin_reg <= cfg_wdata;
                    REG_START1: st1_reg <= cfg_wdata;
                    REG_START2: st2_reg <= cfg_wdata;
                    default:    cos_reg <= cos_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg <= t1_next;
        n1_reg <= n1_next;
        n2_reg <= n2_next;
        order_reg <= order_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        v_reg <= v_next;
        u_reg <= u_next;
        quad_reg <= quad_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
